/* design/sks_pkg.sv */
package sks_pkg;

  localparam int unsigned KEY_W = 12;
  localparam int unsigned TAG_W = 16;

  // one input item
  typedef struct packed {
    logic [KEY_W-1:0] year_key;
    logic [TAG_W-1:0] record_tag;
    logic             last_in;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [KEY_W-1:0] sorted_year;
    logic [TAG_W-1:0] sorted_tag;
    logic             last_out;
    logic             overflow;
  } out_item_t;

  // contents of one cell of the chain
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } cell_rec_t;

  // command broadcast along the chain
  typedef struct packed {
    logic             ins;
    logic             pop;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } cell_ctl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } sks_state_t;

endpackage

/* design/sks_cell.sv */
module sks_cell
  import sks_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      prev_shift,
  input  cell_rec_t prev_rec,
  input  cell_rec_t next_rec,
  output logic      shift,
  output cell_rec_t rec
);

  logic             valid_r;
  logic             valid_nxt;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;
  logic [TAG_W-1:0] tag_r;
  logic [TAG_W-1:0] tag_nxt;

  // this cell moves up on insert if empty or holding a strictly larger key
  assign shift = !valid_r || (key_r > ctl.key);

  assign rec.valid = valid_r;
  assign rec.key   = key_r;
  assign rec.tag   = tag_r;

  // insert: take neighbour below if it also moves, else take the new item;
  // pop: take neighbour above
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    tag_nxt   = tag_r;
    if (ctl.pop) begin
      valid_nxt = next_rec.valid;
      key_nxt   = next_rec.key;
      tag_nxt   = next_rec.tag;
    end else if (ctl.ins && shift) begin
      if (prev_shift) begin
        valid_nxt = prev_rec.valid;
        key_nxt   = prev_rec.key;
        tag_nxt   = prev_rec.tag;
      end else begin
        valid_nxt = 1'b1;
        key_nxt   = ctl.key;
        tag_nxt   = ctl.tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

endmodule

/* design/stable_key_sort_engine.sv */
// Stable key sort engine. Records arrive one per cycle while a set is
// collected and are placed in order at once by a chain of CAPACITY cells:
// every cell holding a strictly larger key moves up one place and the new
// record drops into the gap, so equal keys keep their arrival order. The
// item flagged last_in starts the unload: the set leaves lowest key first,
// one result per cycle while out_ready allows, through an output register,
// with the chain shifting down by one cell per result; input is held off
// until the whole set has left the chain. Records that arrive with the
// chain full are dropped and every result of that set then carries
// overflow.
module stable_key_sort_engine
  import sks_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  sks_state_t state_r;
  sks_state_t state_nxt;
  logic       dropped_r;
  logic       dropped_nxt;
  logic       set_over_r;
  logic       set_over_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_item_r;
  out_item_t  out_item_nxt;

  cell_ctl_t  ctl;
  logic       in_acc;
  logic       full;
  logic       pop;

  logic      [CAPACITY-1:0] shift;
  cell_rec_t [CAPACITY-1:0] rec;
  logic      [CAPACITY-1:0] prev_shift;
  cell_rec_t [CAPACITY-1:0] prev_rec;
  cell_rec_t [CAPACITY-1:0] next_rec;

  assign in_ready = (state_r == ST_FILL);
  assign in_acc   = in_valid && in_ready;
  assign full     = rec[CAPACITY-1].valid;
  assign pop      = (state_r == ST_DRAIN) && (!out_valid_r || out_ready);

  assign ctl.ins = in_acc && !full;
  assign ctl.pop = pop;
  assign ctl.key = in_item.year_key;
  assign ctl.tag = in_item.record_tag;

  // neighbour wiring of the chain
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign prev_shift[gi] = 1'b0;
        assign prev_rec[gi]   = '0;
      end else begin : g_mid
        assign prev_shift[gi] = shift[gi-1];
        assign prev_rec[gi]   = rec[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_top
        assign next_rec[gi] = '0;
      end else begin : g_below
        assign next_rec[gi] = rec[gi+1];
      end

      sks_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .prev_shift (prev_shift[gi]),
        .prev_rec   (prev_rec[gi]),
        .next_rec   (next_rec[gi]),
        .shift      (shift[gi]),
        .rec        (rec[gi])
      );
    end
  endgenerate

  // collect / unload control
  always_comb begin
    state_nxt     = state_r;
    dropped_nxt   = dropped_r;
    set_over_nxt  = set_over_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_FILL: begin
        if (in_acc) begin
          if (in_item.last_in) begin
            set_over_nxt = dropped_r || full;
            dropped_nxt  = 1'b0;
            state_nxt    = ST_DRAIN;
          end else if (full) begin
            dropped_nxt = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (pop) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.sorted_year = rec[0].key;
          out_item_nxt.sorted_tag  = rec[0].tag;
          out_item_nxt.last_out    = !rec[1].valid;
          out_item_nxt.overflow    = set_over_r;
          if (!rec[1].valid) begin
            state_nxt = ST_FILL;
          end
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      dropped_r   <= 1'b0;
      set_over_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dropped_r   <= dropped_nxt;
      set_over_r  <= set_over_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
